// ===== design/vibration_cycle_detector_top_assert.svh =====
`ifndef VIBRATION_CYCLE_DETECTOR_TOP_ASSERT_SVH
`define VIBRATION_CYCLE_DETECTOR_TOP_ASSERT_SVH

// same-cycle implication
`define VCD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vcd port check failed");

// next-cycle implication
`define VCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vcd port check failed");

`endif

// ===== design/vcd_pkg.sv =====
package vcd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int TIME_W     = 32;
    localparam int WEIGHT_W   = 16;
    localparam int COUNT_W    = 24;
    localparam int LIMIT_W    = 31;
    localparam int CFG_DATA_W = 31;
    localparam int CFG_ADDR_W = 3;

    // serial multiplier sizes
    localparam int MUL_OP_W   = 18;
    localparam int MUL_HI_W   = 19;
    localparam int MUL_STEPS  = 16;
    localparam int STEP_CNT_W = 4;

    localparam logic [CFG_ADDR_W-1:0] REG_AVERAGE_WEIGHT   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DEVIATION_WEIGHT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD        = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_COUNT        = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_ACTIVE       = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_QUIET_WAIT       = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_CLEAR_TIMEOUT    = 3'd6;

    localparam logic [WEIGHT_W-1:0] RST_AVERAGE_WEIGHT   = 16'd58982;
    localparam logic [WEIGHT_W-1:0] RST_DEVIATION_WEIGHT = 16'd58982;
    localparam logic [SAMPLE_W-1:0] RST_THRESHOLD        = 16'd100;
    localparam logic [COUNT_W-1:0]  RST_MIN_COUNT        = 24'd10;
    localparam logic [LIMIT_W-1:0]  RST_MIN_ACTIVE       = 31'd60000;
    localparam logic [LIMIT_W-1:0]  RST_QUIET_WAIT       = 31'd60000;
    localparam logic [LIMIT_W-1:0]  RST_CLEAR_TIMEOUT    = 31'd7200000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AVG_MUL,
        ST_DEV_DIFF,
        ST_DEV_ABS,
        ST_DEV_START,
        ST_DEV_MUL,
        ST_VIB,
        ST_CLR_SPAN,
        ST_CLR_TEST,
        ST_STAT_SPAN,
        ST_STAT_OUT
    } state_t;

    typedef struct packed {
        logic                        start;
        logic [WEIGHT_W-1:0]         weight;
        logic signed [MUL_OP_W-1:0]  old_val;
        logic signed [MUL_OP_W-1:0]  x_val;
    } mul_req_t;

    typedef struct packed {
        logic                        done;
        logic                        low_nz;
        logic signed [MUL_HI_W-1:0]  hi;
    } mul_res_t;

    // signed wrapping span strictly above a non-negative limit
    function automatic logic span_exceeds(input logic [TIME_W-1:0] diff,
                                          input logic [LIMIT_W-1:0] limit);
        return !diff[TIME_W-1] && (diff[LIMIT_W-1:0] > limit);
    endfunction

    // x*65536 + w*(old-x), divided by 65536 with truncation toward zero
    function automatic logic [SAMPLE_W-1:0] blend_finish(input mul_res_t r,
                                                         input logic [MUL_OP_W-1:0] x);
        logic [MUL_HI_W:0] sum;
        logic [MUL_HI_W:0] q;
        sum = {r.hi[MUL_HI_W-1], r.hi} + {{(MUL_HI_W+1-MUL_OP_W){x[MUL_OP_W-1]}}, x};
        q = sum + {{MUL_HI_W{1'b0}}, (sum[MUL_HI_W] & r.low_nz)};
        return q[SAMPLE_W-1:0];
    endfunction

endpackage

// ===== design/vcd_ser_mul.sv =====
module vcd_ser_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  vcd_pkg::mul_req_t  req,
    output vcd_pkg::mul_res_t  res
);

    logic                                  busy_reg;
    logic                                  done_reg;
    logic [vcd_pkg::STEP_CNT_W-1:0]        cnt_reg;
    logic [vcd_pkg::WEIGHT_W-1:0]          w_reg;
    logic signed [vcd_pkg::MUL_OP_W-1:0]   d_reg;
    logic signed [vcd_pkg::MUL_HI_W-1:0]   hi_reg;
    logic                                  low_nz_reg;

    logic [vcd_pkg::MUL_HI_W-1:0]          addend;
    logic [vcd_pkg::MUL_HI_W:0]            sum;

    assign addend = w_reg[0] ? {d_reg[vcd_pkg::MUL_OP_W-1], d_reg} : '0;
    assign sum = {hi_reg[vcd_pkg::MUL_HI_W-1], hi_reg}
               + {addend[vcd_pkg::MUL_HI_W-1], addend};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == vcd_pkg::STEP_CNT_W'(vcd_pkg::MUL_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // one weight bit per cycle, product low bits shift out
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            w_reg      <= req.weight;
            d_reg      <= req.old_val - req.x_val;
            hi_reg     <= '0;
            low_nz_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            w_reg      <= w_reg >> 1;
            hi_reg     <= sum[vcd_pkg::MUL_HI_W:1];
            low_nz_reg <= low_nz_reg | sum[0];
        end
    end

    assign res.done   = done_reg;
    assign res.low_nz = low_nz_reg;
    assign res.hi     = hi_reg;

endmodule

// ===== design/vibration_cycle_detector_top.sv =====
// sample item: average blend, deviation difference and magnitude, deviation blend,
// activity, clear test, spans, result register; the blends are 16-step bit-serial multiplies
// query item or first (seeding) sample: spans, then result register; one item at a time
// a waiting result does not block the next transfer in
// rst_n is asynchronous, active low: filters, activity record cleared, registers to defaults
module vibration_cycle_detector_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_en,
    input  logic [vcd_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [vcd_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  mode,
    input  logic signed [vcd_pkg::SAMPLE_W-1:0]   sample,
    input  logic [vcd_pkg::TIME_W-1:0]            time_ms,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  vibrating,
    output logic                                  cycle_started,
    output logic                                  cycle_finished,
    output logic signed [vcd_pkg::SAMPLE_W-1:0]   level_average,
    output logic [vcd_pkg::SAMPLE_W-1:0]          level_deviation
);

    localparam int SW = vcd_pkg::SAMPLE_W;
    localparam int OW = vcd_pkg::MUL_OP_W;

    vcd_pkg::state_t state_reg, state_next;

    logic [vcd_pkg::WEIGHT_W-1:0]  avg_w_reg;
    logic [vcd_pkg::WEIGHT_W-1:0]  dev_w_reg;
    logic [SW-1:0]                 thr_reg;
    logic [vcd_pkg::COUNT_W-1:0]   min_cnt_reg;
    logic [vcd_pkg::LIMIT_W-1:0]   min_act_reg;
    logic [vcd_pkg::LIMIT_W-1:0]   quiet_reg;
    logic [vcd_pkg::LIMIT_W-1:0]   clr_to_reg;

    logic                          seeded_reg;
    logic signed [SW-1:0]          avg_reg;
    logic [SW-1:0]                 dev_reg;
    logic [vcd_pkg::COUNT_W-1:0]   count_reg;
    logic                          act_reg;
    logic [vcd_pkg::TIME_W-1:0]    first_reg;
    logic [vcd_pkg::TIME_W-1:0]    latest_reg;

    logic signed [SW-1:0]          sample_reg;
    logic [vcd_pkg::TIME_W-1:0]    time_reg;
    logic signed [SW:0]            diff_reg;
    logic [SW-1:0]                 xdev_reg;
    logic [vcd_pkg::TIME_W-1:0]    span_a_reg;
    logic [vcd_pkg::TIME_W-1:0]    span_b_reg;

    logic                          out_valid_reg;
    logic                          vib_out_reg;
    logic                          start_out_reg;
    logic                          fin_out_reg;
    logic signed [SW-1:0]          avg_out_reg;
    logic [SW-1:0]                 dev_out_reg;

    logic                          out_load;
    logic                          blend_go;
    logic [SW:0]                   neg_diff;
    vcd_pkg::mul_req_t             mul_req;
    vcd_pkg::mul_res_t             mul_res;

    vcd_ser_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .res   (mul_res)
    );

    assign neg_diff = -diff_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vcd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (!mode && seeded_reg)
                        state_next = vcd_pkg::ST_AVG_MUL;
                    else
                        state_next = vcd_pkg::ST_STAT_SPAN;
                end
            end
            vcd_pkg::ST_AVG_MUL:
            begin
                if (mul_res.done)
                    state_next = vcd_pkg::ST_DEV_DIFF;
            end
            vcd_pkg::ST_DEV_DIFF:  state_next = vcd_pkg::ST_DEV_ABS;
            vcd_pkg::ST_DEV_ABS:   state_next = vcd_pkg::ST_DEV_START;
            vcd_pkg::ST_DEV_START: state_next = vcd_pkg::ST_DEV_MUL;
            vcd_pkg::ST_DEV_MUL:
            begin
                if (mul_res.done)
                    state_next = vcd_pkg::ST_VIB;
            end
            vcd_pkg::ST_VIB:       state_next = vcd_pkg::ST_CLR_SPAN;
            vcd_pkg::ST_CLR_SPAN:  state_next = vcd_pkg::ST_CLR_TEST;
            vcd_pkg::ST_CLR_TEST:  state_next = vcd_pkg::ST_STAT_SPAN;
            vcd_pkg::ST_STAT_SPAN: state_next = vcd_pkg::ST_STAT_OUT;
            vcd_pkg::ST_STAT_OUT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = vcd_pkg::ST_IDLE;
            end
            default:               state_next = vcd_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready         = (state_reg == vcd_pkg::ST_IDLE);
        out_load         = (state_reg == vcd_pkg::ST_STAT_OUT) && (!out_valid_reg || out_ready);
        blend_go         = (state_reg == vcd_pkg::ST_IDLE) && in_valid && !mode && seeded_reg;
        mul_req.start    = blend_go || (state_reg == vcd_pkg::ST_DEV_START);
        if (state_reg == vcd_pkg::ST_IDLE)
        begin
            mul_req.weight  = avg_w_reg;
            mul_req.old_val = {{(OW-SW){avg_reg[SW-1]}}, avg_reg};
            mul_req.x_val   = {{(OW-SW){sample[SW-1]}}, sample};
        end
        else
        begin
            mul_req.weight  = dev_w_reg;
            mul_req.old_val = {{(OW-SW){1'b0}}, dev_reg};
            mul_req.x_val   = {{(OW-SW){1'b0}}, xdev_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= vcd_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_w_reg   <= vcd_pkg::RST_AVERAGE_WEIGHT;
            dev_w_reg   <= vcd_pkg::RST_DEVIATION_WEIGHT;
            thr_reg     <= vcd_pkg::RST_THRESHOLD;
            min_cnt_reg <= vcd_pkg::RST_MIN_COUNT;
            min_act_reg <= vcd_pkg::RST_MIN_ACTIVE;
            quiet_reg   <= vcd_pkg::RST_QUIET_WAIT;
            clr_to_reg  <= vcd_pkg::RST_CLEAR_TIMEOUT;
        end
        else if (cfg_en)
        begin
            case (cfg_addr)
                vcd_pkg::REG_AVERAGE_WEIGHT:   avg_w_reg   <= cfg_data[vcd_pkg::WEIGHT_W-1:0];
                vcd_pkg::REG_DEVIATION_WEIGHT: dev_w_reg   <= cfg_data[vcd_pkg::WEIGHT_W-1:0];
                vcd_pkg::REG_THRESHOLD:        thr_reg     <= cfg_data[SW-1:0];
                vcd_pkg::REG_MIN_COUNT:        min_cnt_reg <= cfg_data[vcd_pkg::COUNT_W-1:0];
                vcd_pkg::REG_MIN_ACTIVE:       min_act_reg <= cfg_data[vcd_pkg::LIMIT_W-1:0];
                vcd_pkg::REG_QUIET_WAIT:       quiet_reg   <= cfg_data[vcd_pkg::LIMIT_W-1:0];
                vcd_pkg::REG_CLEAR_TIMEOUT:    clr_to_reg  <= cfg_data[vcd_pkg::LIMIT_W-1:0];
                default:                       ;
            endcase
        end
    end

    // filter and activity state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeded_reg <= 1'b0;
            avg_reg    <= '0;
            dev_reg    <= '0;
            count_reg  <= '0;
            act_reg    <= 1'b0;
            first_reg  <= '0;
            latest_reg <= '0;
        end
        else
        begin
            case (state_reg)
                vcd_pkg::ST_IDLE:
                begin
                    if (in_valid && !mode && !seeded_reg)
                    begin
                        avg_reg    <= sample;
                        dev_reg    <= '0;
                        seeded_reg <= 1'b1;
                    end
                end
                vcd_pkg::ST_AVG_MUL:
                begin
                    if (mul_res.done)
                        avg_reg <= vcd_pkg::blend_finish(mul_res,
                                       {{(OW-SW){sample_reg[SW-1]}}, sample_reg});
                end
                vcd_pkg::ST_DEV_MUL:
                begin
                    if (mul_res.done)
                        dev_reg <= vcd_pkg::blend_finish(mul_res, {{(OW-SW){1'b0}}, xdev_reg});
                end
                vcd_pkg::ST_VIB:
                begin
                    if (dev_reg > thr_reg)
                    begin
                        if (count_reg != '1)
                            count_reg <= count_reg + 1'b1;
                        if (!act_reg)
                        begin
                            act_reg   <= 1'b1;
                            first_reg <= time_reg;
                        end
                        latest_reg <= time_reg;
                    end
                end
                vcd_pkg::ST_CLR_TEST:
                begin
                    if (act_reg && vcd_pkg::span_exceeds(span_a_reg, clr_to_reg))
                    begin
                        count_reg  <= '0;
                        act_reg    <= 1'b0;
                        first_reg  <= '0;
                        latest_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            vcd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    sample_reg <= sample;
                    time_reg   <= time_ms;
                end
            end
            vcd_pkg::ST_DEV_DIFF:
                diff_reg <= {sample_reg[SW-1], sample_reg} - {avg_reg[SW-1], avg_reg};
            vcd_pkg::ST_DEV_ABS:
                xdev_reg <= diff_reg[SW] ? neg_diff[SW-1:0] : diff_reg[SW-1:0];
            vcd_pkg::ST_CLR_SPAN:
                span_a_reg <= time_reg - first_reg;
            vcd_pkg::ST_STAT_SPAN:
            begin
                span_a_reg <= latest_reg - first_reg;
                span_b_reg <= time_reg - latest_reg;
            end
            vcd_pkg::ST_STAT_OUT:
            begin
                if (out_load)
                begin
                    vib_out_reg   <= dev_reg > thr_reg;
                    start_out_reg <= act_reg && (count_reg != '0);
                    fin_out_reg   <= act_reg && (count_reg > min_cnt_reg)
                                     && vcd_pkg::span_exceeds(span_a_reg, min_act_reg)
                                     && vcd_pkg::span_exceeds(span_b_reg, quiet_reg);
                    avg_out_reg   <= avg_reg;
                    dev_out_reg   <= dev_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign vibrating       = vib_out_reg;
    assign cycle_started   = start_out_reg;
    assign cycle_finished  = fin_out_reg;
    assign level_average   = avg_out_reg;
    assign level_deviation = dev_out_reg;

endmodule

// ===== design/vcd_port_checker.sv =====
`include "vibration_cycle_detector_top_assert.svh"

module vcd_port_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  logic                                  vibrating,
    input  logic                                  cycle_started,
    input  logic                                  cycle_finished,
    input  logic signed [vcd_pkg::SAMPLE_W-1:0]   level_average,
    input  logic [vcd_pkg::SAMPLE_W-1:0]          level_deviation
);

    logic                                  in_xfer;
    logic                                  out_stall;
    logic [2*vcd_pkg::SAMPLE_W+2:0]        status_bits;

    assign in_xfer     = in_valid && in_ready;
    assign out_stall   = out_valid && !out_ready;
    assign status_bits = {vibrating, cycle_started, cycle_finished, level_average,
                          level_deviation};

    // after a transfer, in_ready drops while the block is busy with the item
    `VCD_ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, in_xfer, !in_ready ##1 !in_ready)

    // a finished cycle implies a started one
    `VCD_ASSERT_IMPLY(a_finish_needs_start, clk, rst_n, out_valid && cycle_finished, cycle_started)

    `VCD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(status_bits))

endmodule

bind vibration_cycle_detector_top vcd_port_checker u_port_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
module tb;

    localparam int CFG_ADDR_W = vcd_pkg::CFG_ADDR_W;
    localparam int CFG_DATA_W = vcd_pkg::CFG_DATA_W;
    localparam int SAMPLE_W   = vcd_pkg::SAMPLE_W;
    localparam int TIME_W     = vcd_pkg::TIME_W;
    localparam int WEIGHT_W   = vcd_pkg::WEIGHT_W;
    localparam int COUNT_W    = vcd_pkg::COUNT_W;
    localparam int LIMIT_W    = vcd_pkg::LIMIT_W;

    localparam logic [CFG_ADDR_W-1:0] REG_AVERAGE_WEIGHT   = vcd_pkg::REG_AVERAGE_WEIGHT;
    localparam logic [CFG_ADDR_W-1:0] REG_DEVIATION_WEIGHT = vcd_pkg::REG_DEVIATION_WEIGHT;
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD        = vcd_pkg::REG_THRESHOLD;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_COUNT        = vcd_pkg::REG_MIN_COUNT;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_ACTIVE       = vcd_pkg::REG_MIN_ACTIVE;
    localparam logic [CFG_ADDR_W-1:0] REG_QUIET_WAIT       = vcd_pkg::REG_QUIET_WAIT;
    localparam logic [CFG_ADDR_W-1:0] REG_CLEAR_TIMEOUT    = vcd_pkg::REG_CLEAR_TIMEOUT;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 50;
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic                       op;
        logic signed [SAMPLE_W-1:0] reading;
        logic [TIME_W-1:0]          stamp;
    } sensor_item_t;

    typedef struct packed {
        logic                       vibrating;
        logic                       started;
        logic                       finished;
        logic signed [SAMPLE_W-1:0] average;
        logic [SAMPLE_W-1:0]        deviation;
    } status_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_en = 1'b0;
    logic [CFG_ADDR_W-1:0]      cfg_addr = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic                       mode = 1'b0;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic [TIME_W-1:0]          time_ms = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic                       vibrating;
    logic                       cycle_started;
    logic                       cycle_finished;
    logic signed [SAMPLE_W-1:0] level_average;
    logic [SAMPLE_W-1:0]        level_deviation;

    // detector state as predicted
    logic                       seeded_q;
    logic signed [SAMPLE_W-1:0] avg_q;
    logic [SAMPLE_W-1:0]        dev_q;
    logic [COUNT_W-1:0]         count_q;
    logic                       active_q;
    logic [TIME_W-1:0]          first_q;
    logic [TIME_W-1:0]          latest_q;

    // register shadows
    logic [WEIGHT_W-1:0]        avg_weight;
    logic [WEIGHT_W-1:0]        dev_weight;
    logic [SAMPLE_W-1:0]        threshold;
    logic [COUNT_W-1:0]         min_count;
    logic [LIMIT_W-1:0]         min_active;
    logic [LIMIT_W-1:0]         quiet_wait;
    logic [LIMIT_W-1:0]         clear_timeout;

    sensor_item_t sensor_items[$];
    status_t      expected_status[$];
    sensor_item_t next_item;
    status_t      predicted;
    status_t      observed;

    logic [TIME_W-1:0] stamp_ms;
    logic              in_taken = 1'b0;
    int                send_idle_pct = 0;
    int                stall_pct = 0;
    int                cycle_count = 0;
    int                queued_count = 0;
    int                accepted_count = 0;
    int                checked_count = 0;
    int                finished_count = 0;
    int                vibrating_count = 0;
    int                reg_writes = 0;
    int                error_count = 0;

    vibration_cycle_detector_top uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_en          (cfg_en),
        .cfg_addr        (cfg_addr),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .sample          (sample),
        .time_ms         (time_ms),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .vibrating       (vibrating),
        .cycle_started   (cycle_started),
        .cycle_finished  (cycle_finished),
        .level_average   (level_average),
        .level_deviation (level_deviation)
    );

    always #4 clk = ~clk;

    // exponential filter: keep/65536 of the prior value, truncated toward zero
    function automatic longint weigh(input logic [WEIGHT_W-1:0] keep, input longint prior,
                                     input longint fresh);
        longint k;
        longint acc;
        k = {48'd0, keep};
        acc = k * prior + (64'sd65536 - k) * fresh;
        return acc / 64'sd65536;
    endfunction

    // wrapping time difference read as signed, strictly above the limit
    function automatic logic span_over(input logic [TIME_W-1:0] later,
                                       input logic [TIME_W-1:0] earlier,
                                       input logic [LIMIT_W-1:0] limit);
        int     raw;
        longint gap;
        longint lim;
        raw = later - earlier;
        gap = raw;
        lim = limit;
        return gap > lim;
    endfunction

    function automatic void reset_detector();
        seeded_q      = 1'b0;
        avg_q         = '0;
        dev_q         = '0;
        count_q       = '0;
        active_q      = 1'b0;
        first_q       = '0;
        latest_q      = '0;
        avg_weight    = vcd_pkg::RST_AVERAGE_WEIGHT;
        dev_weight    = vcd_pkg::RST_DEVIATION_WEIGHT;
        threshold     = vcd_pkg::RST_THRESHOLD;
        min_count     = vcd_pkg::RST_MIN_COUNT;
        min_active    = vcd_pkg::RST_MIN_ACTIVE;
        quiet_wait    = vcd_pkg::RST_QUIET_WAIT;
        clear_timeout = vcd_pkg::RST_CLEAR_TIMEOUT;
    endfunction

    function automatic status_t detector_step(input sensor_item_t it);
        status_t r;
        longint  avg_next;
        longint  gap;
        longint  dev_next;
        if (it.op == MODE_SAMPLE) begin
            if (!seeded_q) begin
                avg_q    = it.reading;
                dev_q    = '0;
                seeded_q = 1'b1;
            end
            else begin
                avg_next = weigh(avg_weight, longint'(avg_q), longint'(it.reading));
                avg_q    = avg_next[SAMPLE_W-1:0];
                gap      = longint'(it.reading) - avg_next;
                if (gap < 0)
                    gap = -gap;
                dev_next = weigh(dev_weight, {48'd0, dev_q}, gap);
                dev_q    = dev_next[SAMPLE_W-1:0];
                if (dev_q > threshold) begin
                    if (count_q != {COUNT_W{1'b1}})
                        count_q = count_q + 1'b1;
                    if (!active_q) begin
                        active_q = 1'b1;
                        first_q  = it.stamp;
                    end
                    latest_q = it.stamp;
                end
                if (active_q && span_over(it.stamp, first_q, clear_timeout)) begin
                    count_q  = '0;
                    active_q = 1'b0;
                    first_q  = '0;
                    latest_q = '0;
                end
            end
        end
        r.vibrating = dev_q > threshold;
        r.started   = active_q && (count_q != '0);
        r.finished  = active_q && (count_q > min_count)
                      && span_over(latest_q, first_q, min_active)
                      && span_over(it.stamp, latest_q, quiet_wait);
        r.average   = avg_q;
        r.deviation = dev_q;
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] clip16(input int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // driver
    always @(negedge clk) begin
        if (!in_valid || in_taken) begin
            if (sensor_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_item = sensor_items.pop_front();
                in_valid <= 1'b1;
                mode     <= next_item.op;
                sample   <= next_item.reading;
                time_ms  <= next_item.stamp;
            end
            else begin
                in_valid <= 1'b0;
            end
        end
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // monitor and scoreboard
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d status results still pending",
                     cycle_count, expected_status.size());
            $display("vibration_cycle_detector_top regression: fail");
            $finish;
        end
        else if (rst_n) begin
            in_taken = in_valid && in_ready;
            if (in_taken) begin
                predicted = detector_step(sensor_item_t'{op: mode, reading: sample,
                                                         stamp: time_ms});
                expected_status.push_back(predicted);
                accepted_count++;
            end
            if (out_valid && out_ready) begin
                observed = '{vibrating: vibrating, started: cycle_started,
                             finished: cycle_finished, average: level_average,
                             deviation: level_deviation};
                if (expected_status.size() == 0) begin
                    $display("%0t ns: status transfer with nothing pending, expected none, got %p",
                             $time, observed);
                    error_count++;
                end
                else begin
                    predicted = expected_status.pop_front();
                    report_field("vibrating", predicted.vibrating, observed.vibrating);
                    report_field("cycle_started", predicted.started, observed.started);
                    report_field("cycle_finished", predicted.finished, observed.finished);
                    report_field("level_average", predicted.average, observed.average);
                    report_field("level_deviation", predicted.deviation, observed.deviation);
                    if (predicted.finished)
                        finished_count++;
                    if (predicted.vibrating)
                        vibrating_count++;
                    checked_count++;
                end
            end
        end
    end

    task automatic add_item(input logic op, input logic signed [SAMPLE_W-1:0] reading,
                            input logic [TIME_W-1:0] stamp);
        sensor_items.push_back(sensor_item_t'{op: op, reading: reading, stamp: stamp});
        queued_count++;
    endtask

    task automatic add_noise();
        add_item(1'($urandom_range(1)), 16'($urandom), $urandom);
    endtask

    task automatic settle();
        while (accepted_count != queued_count || expected_status.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_en   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_en <= 1'b0;
        case (idx)
            REG_AVERAGE_WEIGHT:   avg_weight = val[WEIGHT_W-1:0];
            REG_DEVIATION_WEIGHT: dev_weight = val[WEIGHT_W-1:0];
            REG_THRESHOLD:        threshold = val[SAMPLE_W-1:0];
            REG_MIN_COUNT:        min_count = val[COUNT_W-1:0];
            REG_MIN_ACTIVE:       min_active = val[LIMIT_W-1:0];
            REG_QUIET_WAIT:       quiet_wait = val[LIMIT_W-1:0];
            REG_CLEAR_TIMEOUT:    clear_timeout = val[LIMIT_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic set_idling(input int phase);
        case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 82; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 82; end
            default: begin send_idle_pct = 28; stall_pct = 28; end
        endcase
    endtask

    task automatic randomize_limits();
        write_reg(REG_AVERAGE_WEIGHT, 31'(($urandom_range(99) < 80) ?
                  $urandom_range(65535, 32768) : $urandom_range(65535)));
        write_reg(REG_DEVIATION_WEIGHT, 31'(($urandom_range(99) < 80) ?
                  $urandom_range(65535, 32768) : $urandom_range(65535)));
        write_reg(REG_THRESHOLD, 31'($urandom_range(800, 20)));
        write_reg(REG_MIN_COUNT, 31'($urandom_range(12)));
        write_reg(REG_MIN_ACTIVE, 31'($urandom_range(40000)));
        write_reg(REG_QUIET_WAIT, 31'($urandom_range(40000)));
        write_reg(REG_CLEAR_TIMEOUT, 31'(($urandom_range(1) == 1) ?
                  $urandom_range(2000000, 100000) : $urandom_range(60000, 5000)));
    endtask

    // quiet lead-in, vibration burst, status polls, quiet tail
    task automatic add_wash_cycle();
        int     base;
        int     amp;
        int     burst;
        int     k;
        longint stride;
        base = int'($urandom_range(2000)) - 1000;
        amp  = int'(threshold) * 2 + int'($urandom_range(3000, 50));
        if (amp > 30000)
            amp = 30000;
        repeat ($urandom_range(4, 1)) begin
            stamp_ms += $urandom_range(5000, 100);
            add_item(MODE_SAMPLE, clip16(base + int'($urandom_range(20)) - 10), stamp_ms);
        end
        burst = int'(min_count > 24'd40 ? 24'd40 : min_count) + int'($urandom_range(8, 3));
        if (burst > 40)
            burst = 40;
        if ($urandom_range(99) < 20)
            burst = $urandom_range(burst, 1);
        stride = longint'({1'b0, min_active}) / burst + $urandom_range(3000, 1);
        if ($urandom_range(99) < 15)
            stride = $urandom_range(500, 1);
        for (k = 0; k < burst; k++) begin
            stamp_ms += stride[TIME_W-1:0];
            add_item(MODE_SAMPLE, clip16(base + ((k % 2 == 1) ? amp : -amp)), stamp_ms);
            if ($urandom_range(99) < 8)
                add_noise();
        end
        repeat ($urandom_range(3, 1)) begin
            case ($urandom_range(2))
                0: add_item(MODE_QUERY, 16'($urandom),
                            stamp_ms + {1'b0, quiet_wait} + $urandom_range(2));
                1: begin
                    stamp_ms += {1'b0, quiet_wait} + $urandom_range(100000);
                    add_item(MODE_QUERY, 16'($urandom), stamp_ms);
                end
                default: add_item(MODE_QUERY, 16'($urandom), stamp_ms - $urandom_range(5000));
            endcase
        end
        if ($urandom_range(3) == 0)
            stamp_ms += {1'b0, clear_timeout} + $urandom_range(2);
        repeat ($urandom_range(6, 2)) begin
            add_item(MODE_SAMPLE, clip16(base + int'($urandom_range(20)) - 10), stamp_ms);
            stamp_ms += $urandom_range(20000, 100);
            if ($urandom_range(3) == 0)
                add_item(MODE_QUERY, 16'($urandom), stamp_ms);
        end
    endtask

    task automatic fill_random(input int n);
        int start;
        start = queued_count;
        stamp_ms = ($urandom_range(1) == 1) ? $urandom : 32'hffff_ffff - $urandom_range(200000);
        while (queued_count - start < n) begin
            if ($urandom_range(99) < 85)
                add_wash_cycle();
            else
                repeat ($urandom_range(4, 1)) add_noise();
        end
    endtask

    task automatic add_directed();
        int k;
        add_item(MODE_QUERY, 16'sh7fff, 32'd0);
        add_item(MODE_SAMPLE, 16'sh8000, 32'hffff_ffff);
        for (k = 0; k < 12; k++)
            add_item(MODE_SAMPLE, (k % 3 == 0) ? 16'sh7fff : ((k % 3 == 1) ? 16'sh8000 : 16'sd0),
                     6000 * (k + 1));
        // quiet wait boundary, negative spans
        add_item(MODE_QUERY, 16'sd0, 32'd132000);
        add_item(MODE_QUERY, 16'sh8000, 32'd132001);
        add_item(MODE_QUERY, 16'sd1, 32'd50000);
        add_item(MODE_QUERY, 16'sd0, 32'hffff_ffff);
        // clear timeout boundary
        add_item(MODE_SAMPLE, 16'sd0, 32'd7206000);
        add_item(MODE_SAMPLE, 16'sd0, 32'd7206001);
        add_item(MODE_QUERY, 16'sd0, 32'd7300000);
    endtask

    initial begin
        int phase;
        reset_detector();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_idling(0);
        add_directed();
        settle();

        for (phase = 0; phase < 6; phase++) begin
            set_idling(phase);
            randomize_limits();
            fill_random(50);
            settle();
        end

        // upper extremes of every register plus an unmapped index
        set_idling(3);
        write_reg(REG_AVERAGE_WEIGHT, 31'd65535);
        write_reg(REG_DEVIATION_WEIGHT, 31'd65535);
        write_reg(REG_THRESHOLD, 31'd65535);
        write_reg(REG_MIN_COUNT, 31'hff_ffff);
        write_reg(REG_MIN_ACTIVE, 31'h7fff_ffff);
        write_reg(REG_QUIET_WAIT, 31'h7fff_ffff);
        write_reg(REG_CLEAR_TIMEOUT, 31'h7fff_ffff);
        write_reg(REG_UNUSED, 31'($urandom));
        add_item(MODE_SAMPLE, 16'sh7fff, 32'd0);
        add_item(MODE_SAMPLE, 16'sh8000, 32'hffff_ffff);
        add_item(MODE_QUERY, 16'sh8000, 32'd0);
        fill_random(20);
        settle();

        // lower extremes, then the widest deviation step
        set_idling(1);
        write_reg(REG_AVERAGE_WEIGHT, 31'd0);
        write_reg(REG_DEVIATION_WEIGHT, 31'd0);
        write_reg(REG_THRESHOLD, 31'd0);
        write_reg(REG_MIN_COUNT, 31'd0);
        write_reg(REG_MIN_ACTIVE, 31'd0);
        write_reg(REG_QUIET_WAIT, 31'd0);
        write_reg(REG_CLEAR_TIMEOUT, 31'd0);
        add_item(MODE_SAMPLE, 16'sh7fff, 32'd1000);
        add_item(MODE_SAMPLE, 16'sh8000, 32'd1001);
        add_item(MODE_QUERY, 16'sd0, 32'd1002);
        settle();
        write_reg(REG_AVERAGE_WEIGHT, 31'd65535);
        write_reg(REG_THRESHOLD, 31'd65533);
        add_item(MODE_SAMPLE, 16'sh7fff, 32'd2000);
        add_item(MODE_QUERY, 16'sd0, 32'd2000);
        add_item(MODE_QUERY, 16'sd0, 32'd2001);
        add_item(MODE_SAMPLE, 16'sh8000, 32'd3000);
        add_item(MODE_QUERY, 16'sd0, 32'd3001);
        settle();
        set_idling(2);
        write_reg(REG_AVERAGE_WEIGHT, 31'd32768);
        write_reg(REG_DEVIATION_WEIGHT, 31'd32768);
        fill_random(25);
        settle();

        $display("%0d sensor transfers (%0d register writes), %0d status results checked",
                 accepted_count, reg_writes, checked_count);
        $display("%0d results vibrating, %0d with a finished cycle", vibrating_count,
                 finished_count);
        if (error_count == 0)
            $display("vibration_cycle_detector_top regression: pass");
        else
            $display("vibration_cycle_detector_top regression: fail");
        $finish;
    end

endmodule

// ===== vibration_cycle_detector_top.f =====
+incdir+design
design/vcd_pkg.sv
design/vcd_ser_mul.sv
design/vibration_cycle_detector_top.sv
design/vcd_port_checker.sv
tb/tb.sv
